FILE: src/fbpa_pkg.sv
// Shared types, constants and control structs of the fixed block pool allocator.
package fbpa_pkg;

	localparam int DEF_MAX_BLOCKS = 256;

	// Bitmap row geometry
	localparam int WORD_W   = 32;
	localparam int WORD_LOG = 5;

	// Field widths
	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 9;
	localparam int IDX_OUT_W = 8;
	localparam int CFG_IDX_W = 2;

	// Command codes
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_SIZE   = 3'd2,
		ST_RANGE  = 3'd3,
		ST_UNUSED = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_SIZE  = 2'd1,
		CFG_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ACQ_RD,
		S_ACQ_MARK,
		S_SCAN,
		S_SCAN_LD,
		S_REL_LIM,
		S_DIV,
		S_REL_RD,
		S_REL_WR,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load_in;
		logic    prep;
		logic    take_hint;
		logic    mem_rd;
		logic    acq_mark;
		logic    scan_hit;
		logic    scan_next;
		logic    scan_ld;
		logic    div_init;
		logic    div_step;
		logic    rel_wr;
		logic    fail;
		status_t fail_code;
		logic    load_out;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_rel;
		logic size_ok;
		logic hint_ok;
		logic base_ok;
		logic in_limit;
		logic div_last;
		logic scan_found;
		logic scan_more;
	} dp_stat_t;

endpackage

FILE: src/fbpa_ctrl.sv
// Sequencing state machine of the fixed block pool allocator.
module fbpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fbpa_pkg::dp_stat_t  stat,
	output fbpa_pkg::dp_cmd_t   ctl
);
	import fbpa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output beat holding register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.prep = 1'b1;
				if (stat.is_rel) begin
					if (!stat.base_ok) begin
						ctl.fail      = 1'b1;
						ctl.fail_code = ST_RANGE;
						state_d       = S_DONE;
					end else begin
						state_d = S_REL_LIM;
					end
				end else if (!stat.size_ok) begin
					ctl.fail      = 1'b1;
					ctl.fail_code = ST_SIZE;
					state_d       = S_DONE;
				end else if (!stat.hint_ok) begin
					ctl.fail      = 1'b1;
					ctl.fail_code = ST_FULL;
					state_d       = S_DONE;
				end else begin
					ctl.take_hint = 1'b1;
					state_d       = S_ACQ_RD;
				end
			end
			S_ACQ_RD: begin
				ctl.mem_rd = 1'b1;
				state_d    = S_ACQ_MARK;
			end
			S_ACQ_MARK: begin
				ctl.acq_mark = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_found) begin
					ctl.scan_hit = 1'b1;
					state_d      = S_DONE;
				end else if (stat.scan_more) begin
					ctl.scan_next = 1'b1;
					state_d       = S_SCAN_LD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN_LD: begin
				ctl.scan_ld = 1'b1;
				state_d     = S_SCAN;
			end
			S_REL_LIM: begin
				if (!stat.in_limit) begin
					ctl.fail      = 1'b1;
					ctl.fail_code = ST_RANGE;
					state_d       = S_DONE;
				end else begin
					ctl.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_REL_RD;
				end
			end
			S_REL_RD: begin
				ctl.mem_rd = 1'b1;
				state_d    = S_REL_WR;
			end
			S_REL_WR: begin
				ctl.rel_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/fbpa_dp.sv
// Datapath of the fixed block pool allocator: config, bitmap memory, hint, divider, scan.
module fbpa_dp #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                             cmd,
	input  logic [fbpa_pkg::SIZE_W-1:0]      request_size,
	input  logic [fbpa_pkg::ADDR_W-1:0]      release_address,
	input  fbpa_pkg::dp_cmd_t                ctl,
	output fbpa_pkg::dp_stat_t               stat,
	output logic [fbpa_pkg::ADDR_W-1:0]      block_address,
	output logic [fbpa_pkg::IDX_OUT_W-1:0]   block_index,
	output fbpa_pkg::status_t                status
);
	import fbpa_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int ROWS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int REM_W  = IDX_W + SIZE_W;
	localparam int PROD_W = CNT_W + SIZE_W;
	localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	// Config registers
	logic [ADDR_W-1:0]  base_q;
	logic [SIZE_W-1:0]  bsize_q;
	logic [COUNT_W-1:0] bcount_q;

	// Latched input beat
	logic              cmd_q;
	logic [SIZE_W-1:0] req_q;
	logic [ADDR_W-1:0] addr_q;

	// Free hint
	logic [IDX_W-1:0] ff_q;
	logic             ffv_q;

	// Working registers
	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0] offset_q;
	logic [REM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] word_q;
	logic [ROW_W-1:0]  scan_row_q;
	logic [IDX_W:0]    scan_start_q;

	// Bitmap memory, rows valid after first write
	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rdata_q;
	logic              rv_rd_q;
	logic [ROWS-1:0]   rv_q;

	// Result and output registers
	logic [ADDR_W-1:0]    res_addr_q, out_addr_q;
	logic [IDX_OUT_W-1:0] res_idx_q, out_idx_q;
	status_t              res_status_q, out_status_q;

	logic [CNT_W-1:0]    count_w;
	logic [ROW_W-1:0]    row_w;
	logic [WORD_LOG-1:0] bit_w;
	logic [WORD_W-1:0]   mask_w;
	logic [WORD_W-1:0]   rdata_m;
	logic                found_w;
	logic                we_w;
	logic [WORD_W-1:0]   wdata_w;
	logic [ROW_W-1:0]    rd_addr_w;
	logic                rd_en_w;
	logic [CNT_W-1:0]    mul_a_w;
	logic [REM_W-1:0]    dsh_w;
	logic                ge_w;
	logic [WORD_W-1:0]   cand_w;
	logic [WORD_LOG-1:0] hit_pos_w;
	logic [IDX_W-1:0]    hit_idx_w;
	logic [31:0]         next_row_w;

	// Effective block count
	always_comb begin
		if (32'(bcount_q) < 32'(MAX_BLOCKS)) begin
			count_w = CNT_W'(bcount_q);
		end else begin
			count_w = CNT_W'(MAX_BLOCKS);
		end
	end

	// Row and bit of the current index
	assign row_w   = ROW_W'(32'(idx_q) >> WORD_LOG);
	assign bit_w   = WORD_LOG'(idx_q);
	assign mask_w  = WORD_W'(1) << bit_w;
	assign rdata_m = rv_rd_q ? rdata_q : '0;
	assign found_w = rdata_m[bit_w];

	// Bitmap write: set on acquire, clear on release of a used block
	assign we_w    = ctl.acq_mark | (ctl.rel_wr & found_w);
	assign wdata_w = ctl.acq_mark ? (rdata_m | mask_w) : (rdata_m & ~mask_w);

	assign next_row_w = 32'(scan_row_q) + 32'd1;
	assign rd_addr_w  = ctl.scan_next ? ROW_W'(next_row_w) : row_w;
	assign rd_en_w    = ctl.mem_rd | ctl.scan_next;

	always_ff @(posedge clk) begin
		if (we_w) begin
			mem[row_w] <= wdata_w;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_w) begin
			rdata_q <= mem[rd_addr_w];
			rv_rd_q <= rv_q[rd_addr_w];
		end
	end

	// Shared multiplier operand: hint index on acquire, count on release
	assign mul_a_w = cmd_q ? count_w : CNT_W'(ff_q);

	// Restoring divider step
	assign dsh_w = REM_W'(bsize_q) << step_q;
	assign ge_w  = rem_q >= dsh_w;

	// Free-block search in the current row
	always_comb begin
		logic [31:0] g;
		for (int b = 0; b < WORD_W; b++) begin
			g = (32'(scan_row_q) << WORD_LOG) | 32'(b);
			cand_w[b] = !word_q[b] && (g >= 32'(scan_start_q)) && (g < 32'(count_w));
		end
	end

	always_comb begin
		hit_pos_w = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand_w[b]) begin
				hit_pos_w = WORD_LOG'(b);
			end
		end
	end

	assign hit_idx_w = IDX_W'((32'(scan_row_q) << WORD_LOG) | 32'(hit_pos_w));

	// Status to controller
	assign stat.is_rel     = (cmd_q == CMD_RELEASE);
	assign stat.size_ok    = (bsize_q != '0) && (req_q == bsize_q);
	assign stat.hint_ok    = ffv_q && (32'(ff_q) < 32'(count_w));
	assign stat.base_ok    = (bsize_q != '0) && (addr_q >= base_q);
	assign stat.in_limit   = offset_q < 32'(prod_q);
	assign stat.div_last   = (step_q == '0);
	assign stat.scan_found = |cand_w;
	assign stat.scan_more  = (next_row_w < 32'(ROWS)) &&
	                         ((next_row_w << WORD_LOG) < 32'(count_w));

	// Config, hint and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bsize_q  <= SIZE_W'(64);
			bcount_q <= COUNT_W'(256);
			ff_q     <= '0;
			ffv_q    <= 1'b1;
			rv_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_BASE:  base_q   <= cfg_data;
					CFG_SIZE:  bsize_q  <= cfg_data[SIZE_W-1:0];
					CFG_COUNT: bcount_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (we_w) begin
				rv_q[row_w] <= 1'b1;
			end
			if (ctl.acq_mark) begin
				ffv_q <= 1'b0;
			end
			if (ctl.scan_hit) begin
				ff_q  <= hit_idx_w;
				ffv_q <= 1'b1;
			end
			// Released block lowers the hint or refills an empty one
			if (ctl.rel_wr && found_w && (!ffv_q || idx_q < ff_q)) begin
				ff_q  <= idx_q;
				ffv_q <= 1'b1;
			end
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= cmd;
			req_q  <= request_size;
			addr_q <= release_address;
		end
		if (ctl.prep) begin
			prod_q   <= PROD_W'(mul_a_w) * PROD_W'(bsize_q);
			offset_q <= addr_q - base_q;
		end
		if (ctl.take_hint) begin
			idx_q <= ff_q;
		end
		if (ctl.acq_mark) begin
			word_q       <= wdata_w;
			scan_row_q   <= row_w;
			scan_start_q <= (IDX_W + 1)'(idx_q) + 1'b1;
			res_status_q <= ST_OK;
			res_idx_q    <= IDX_OUT_W'(idx_q);
			res_addr_q   <= base_q + ADDR_W'(prod_q);
		end
		if (ctl.scan_next) begin
			scan_row_q <= ROW_W'(next_row_w);
		end
		if (ctl.scan_ld) begin
			word_q <= rdata_m;
		end
		if (ctl.div_init) begin
			rem_q  <= REM_W'(offset_q);
			idx_q  <= '0;
			step_q <= STEP_W'(IDX_W - 1);
		end
		if (ctl.div_step) begin
			if (ge_w) begin
				rem_q <= rem_q - dsh_w;
			end
			idx_q  <= (idx_q << 1) | IDX_W'(ge_w);
			step_q <= step_q - 1'b1;
		end
		if (ctl.rel_wr) begin
			res_status_q <= found_w ? ST_OK : ST_UNUSED;
			res_idx_q    <= IDX_OUT_W'(idx_q);
			res_addr_q   <= '0;
		end
		if (ctl.fail) begin
			res_status_q <= ctl.fail_code;
			res_idx_q    <= '0;
			res_addr_q   <= '0;
		end
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_addr_q   <= res_addr_q;
		end
	end

	assign block_address = out_addr_q;
	assign block_index   = out_idx_q;
	assign status        = out_status_q;

endmodule

FILE: src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator.
// Hands out and takes back equal-size blocks of a pool that starts at the configured base; every
// input beat (acquire or release) yields exactly one result beat with a status code. Items
// are worked one at a time. An acquire checks the request, reads and marks the bitmap row of
// the hinted block, then searches for the next free block one further 32-block row at a time
// (the bitmap is a memory of 32-bit rows, read one row at a time). A release checks the range,
// finds the index with a restoring divider that resolves one index bit per cycle, then reads
// and writes back its bitmap row. A finished result sits in an output register, so the next
// item is taken while it waits. The bitmap starts all free after reset with no clearing pass;
// the user writes config registers only while idle; the block itself does not enforce it.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [fbpa_pkg::SIZE_W-1:0]      request_size,
	input  logic [fbpa_pkg::ADDR_W-1:0]      release_address,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbpa_pkg::ADDR_W-1:0]      block_address,
	output logic [fbpa_pkg::IDX_OUT_W-1:0]   block_index,
	output fbpa_pkg::status_t                status
);
	import fbpa_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.request_size    (request_size),
		.release_address (release_address),
		.ctl             (ctl),
		.stat            (stat),
		.block_address   (block_address),
		.block_index     (block_index),
		.status          (status)
	);

`ifndef SYNTHESIS
	// Only a successful acquire carries an address
	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_address == '0)
		else $error("nonzero address on a failed result");

	// Out-of-pool results carry index zero
	a_idx_zero_on_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> block_index == '0)
		else $error("nonzero index on an out-of-pool result");

	// One item at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// Result register is loaded only when free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !out_valid || out_ready)
		else $error("pending result beat overwritten");
`endif

endmodule

FILE: verif/fbpa_checker.sv
// Scoreboard for the fixed block pool allocator: mirrors the pool and checks every result beat.
module fbpa_checker #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic                             cmd,
	input  logic [fbpa_pkg::SIZE_W-1:0]      request_size,
	input  logic [fbpa_pkg::ADDR_W-1:0]      release_address,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [fbpa_pkg::ADDR_W-1:0]      block_address,
	input  logic [fbpa_pkg::IDX_OUT_W-1:0]   block_index,
	input  fbpa_pkg::status_t                status,
	output int                               fail_count,
	output int                               pending,
	output int                               checked
);
	import fbpa_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [IDX_OUT_W-1:0] index;
		status_t              code;
	} grant_t;

	// Mirrored pool state and registers
	bit                in_use [MAX_BLOCKS];
	int unsigned       hint;
	bit                hint_ok;
	logic [ADDR_W-1:0] pool_base;
	logic [SIZE_W-1:0] pool_size;
	logic [COUNT_W-1:0] pool_count;

	// Grants still owed by the block, oldest first
	grant_t due_grants [$];

	// Work out the grant for one command beat and update the mirrored pool
	function automatic grant_t serve(input logic op, input logic [SIZE_W-1:0] req,
			input logic [ADDR_W-1:0] addr);
		grant_t      g;
		int unsigned limit;
		int unsigned idx;
		int unsigned j;
		logic [ADDR_W-1:0] offset;
		g.addr = '0;
		g.index = '0;
		g.code = ST_OK;
		limit = (pool_count < MAX_BLOCKS) ? pool_count : MAX_BLOCKS;
		if (op == CMD_ACQUIRE) begin
			if (pool_size == 0 || req != pool_size) begin
				g.code = ST_SIZE;
			end else if (!hint_ok || hint >= limit) begin
				g.code = ST_FULL;
			end else begin
				idx = hint;
				g.addr = pool_base + 32'(idx * pool_size);
				g.index = 8'(idx);
				in_use[idx] = 1'b1;
				// look upward for the next free block, below the count only
				hint_ok = 1'b0;
				for (j = idx + 1; j < limit; j++) begin
					if (!in_use[j]) begin
						hint = j;
						hint_ok = 1'b1;
						break;
					end
				end
			end
		end else begin
			if (pool_size == 0 || addr < pool_base) begin
				g.code = ST_RANGE;
			end else begin
				offset = addr - pool_base;
				idx = offset / pool_size;
				if (idx >= limit) begin
					g.code = ST_RANGE;
				end else if (!in_use[idx]) begin
					g.code = ST_UNUSED;
					g.index = 8'(idx);
				end else begin
					in_use[idx] = 1'b0;
					g.index = 8'(idx);
					// a release into a full pool revives the hint, and a lower index lowers it
					if (!hint_ok || idx < hint) begin
						hint = idx;
						hint_ok = 1'b1;
					end
				end
			end
		end
		return g;
	endfunction

	// Result beats are checked before the same edge's command beat is predicted
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (in_use[k]) in_use[k] = 1'b0;
			hint = 0;
			hint_ok = 1'b1;
			pool_base = '0;
			pool_size = 16'd64;
			pool_count = 9'd256;
			due_grants.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_grants.size() == 0) begin
					$display("%0t: result beat with nothing owed: address %h index %0d status %0d",
						$time, block_address, block_index, status);
					fail_count++;
				end else begin
					want = due_grants.pop_front();
					checked++;
					if (block_address !== want.addr) begin
						$display("%0t: block_address expected %h actual %h",
							$time, want.addr, block_address);
						fail_count++;
					end
					if (block_index !== want.index) begin
						$display("%0t: block_index expected %0d actual %0d",
							$time, want.index, block_index);
						fail_count++;
					end
					if (status !== want.code) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.code, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				due_grants.push_back(serve(cmd, request_size, release_address));
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_BASE:  pool_base = cfg_data;
					CFG_SIZE:  pool_size = cfg_data[SIZE_W-1:0];
					CFG_COUNT: pool_count = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
		end
		pending = due_grants.size();
	end

endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for the fixed block pool allocator test.
module testbench;
	import fbpa_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic [SIZE_W-1:0]    request_size;
	logic [ADDR_W-1:0]    release_address;
	logic                 out_valid;
	logic                 out_ready;
	logic [ADDR_W-1:0]    block_address;
	logic [IDX_OUT_W-1:0] block_index;
	status_t              status;
	int                   fail_count;
	int                   pending;
	int                   checked;

	// Stimulus bookkeeping
	logic [ADDR_W-1:0] cur_base;
	int unsigned       cur_size;
	int unsigned       cur_count;
	bit                gaps_on = 1'b1;
	bit                stall_on = 1'b1;
	bit                long_hold = 1'b0;
	bit                hold_served = 1'b0;
	int                n_acq = 0;
	int                n_rel = 0;
	int                n_settings = 0;

	fixed_block_pool_allocator dut (.*);

	fbpa_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on run length
	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one command beat, after a random idle burst now and then
	task automatic send_item(input logic c, input logic [SIZE_W-1:0] req,
			input logic [ADDR_W-1:0] a);
		int gap;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		request_size <= req;
		release_address <= a;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_ACQUIRE)
			n_acq++;
		else
			n_rel++;
	endtask

	task automatic take(input logic [SIZE_W-1:0] req);
		send_item(CMD_ACQUIRE, req, $urandom);
	endtask

	task automatic give_back(input logic [ADDR_W-1:0] a);
		send_item(CMD_RELEASE, 16'($urandom), a);
	endtask

	// Stop offering and wait until every owed grant has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Program all three pool registers back to back
	task automatic set_pool(input logic [ADDR_W-1:0] b, input int unsigned s,
			input int unsigned c);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= CFG_SIZE;
		cfg_data <= 32'(s);
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_data <= 32'(c);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_base = b;
		cur_size = s;
		cur_count = c;
		n_settings++;
	endtask

	// Mostly well-formed acquires and in-pool releases, some noise
	task automatic random_item(input int acq_pct);
		logic [SIZE_W-1:0] req;
		logic [ADDR_W-1:0] a;
		int unsigned       idx;
		int unsigned       pick;
		req = 16'($urandom);
		a = $urandom;
		pick = $urandom_range(0, 9);
		if ($urandom_range(1, 100) <= acq_pct) begin
			if (pick < 9)
				req = 16'(cur_size);
			else if ($urandom_range(0, 1))
				req = 16'(cur_size + 1);
			send_item(CMD_ACQUIRE, req, a);
		end else begin
			idx = $urandom_range(0, cur_count - 1);
			if (pick < 8)
				a = cur_base + 32'(idx * cur_size) + 32'($urandom_range(0, cur_size - 1));
			else if (pick == 8)
				a = cur_base - 1;
			else if ($urandom_range(0, 1))
				a = cur_base + 32'(cur_count * cur_size);
			send_item(CMD_RELEASE, req, a);
		end
	endtask

	// Output side: random stalls, plus one long hold to back the block up
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && !hold_served) begin
				hold_served = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Main stimulus
	initial begin
		logic [ADDR_W-1:0] b;
		int unsigned       s;
		int unsigned       c;
		int                acq_pct;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_ACQUIRE;
		request_size = '0;
		release_address = '0;
		cur_base = '0;
		cur_size = 64;
		cur_count = 256;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: sizes, zero address, free block, unaligned, out of range
		take(16'd64);
		take(16'd0);
		take(16'hFFFF);
		give_back(32'd0);
		give_back(32'd0);
		take(16'd64);
		take(16'd64);
		give_back(32'd127);
		give_back(32'd16384);
		give_back(32'hFFFF_FFFF);
		drain();

		// Two-block pool: fill it, address below base, release into a full pool
		set_pool(32'h1000, 16, 2);
		take(16'd16);
		take(16'd16);
		give_back(32'h0FFF);
		give_back(32'h1005);
		take(16'd16);
		drain();

		// Count grows while full: still full until something is released
		set_pool(32'h1000, 16, 4);
		take(16'd16);
		give_back(32'h1010);
		take(16'd16);
		take(16'd16);
		drain();

		// Zero block size
		set_pool(32'h1000, 0, 4);
		take(16'd0);
		give_back(32'h1000);
		drain();

		// Random phases over many pool settings
		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 0) begin
				b = 32'hFFFF_FFFF;
				s = 65535;
				c = 256;
			end else if (ph == 1) begin
				b = '0;
				s = 1;
				c = 1;
			end else begin
				case ($urandom_range(0, 3))
					0: b = '0;
					1: b = 32'hFFFF_FFFF;
					2: b = $urandom;
					default: b = $urandom & 32'hFFFF_0000;
				endcase
				case ($urandom_range(0, 3))
					0: s = 1;
					1: s = 65535;
					2: s = $urandom_range(1, 64);
					default: s = $urandom_range(1, 65535);
				endcase
				case ($urandom_range(0, 4))
					0: c = 1;
					1: c = 2;
					2: c = $urandom_range(3, 16);
					3: c = 256;
					default: c = $urandom_range(1, 256);
				endcase
			end
			// quiet stretches mid-run and for the whole last phase
			gaps_on = (ph % 4 != 3) && (ph != 12);
			stall_on = (ph % 4 != 3) && (ph != 12);
			if (ph == 2)
				long_hold = 1'b1;
			set_pool(b, s, c);
			acq_pct = (ph % 3 == 0) ? 75 : ((ph % 3 == 1) ? 50 : 30);
			repeat (100) random_item(acq_pct);
			drain();
		end

		repeat (30) @(posedge clk);
		$display("Covered %0d acquire and %0d release beats over %0d pool settings, %0d checked.",
			n_acq, n_rel, n_settings, checked);
		$display("Both sides idled at random, with one %0d-cycle output hold.", HOLD_CYCLES);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/fbpa_pkg.sv
src/fbpa_ctrl.sv
src/fbpa_dp.sv
src/fixed_block_pool_allocator.sv
verif/fbpa_checker.sv
verif/testbench.sv
